// File: sv/ecal_pkg.sv
`timescale 1ns / 1ps

package ecal_pkg;

  // pipeline depth: split (3), calendar and time of day (7)
  localparam int NUM_STAGES = 10;

  // payload widths
  localparam int EPOCH_W = 64;
  localparam int SEC_W   = 6;
  localparam int MIN_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int MDAY_W  = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 14;
  localparam int WDAY_W  = 3;

  // internal widths
  localparam int DAYS_W = 22;
  localparam int SOD_W  = 17;

  // saturation: first second past 9999-12-31 23:59:59
  localparam logic [DAYS_W-1:0]  LAST_DAY = 22'd2932896;
  localparam logic [SOD_W-1:0]   LAST_SOD = 17'd86399;
  localparam logic [EPOCH_W-1:0] SAT_SECS = 64'd253402300800;

  // day count from 0000-03-01 and weekday bias
  localparam logic [DAYS_W-1:0] MARCH_OFS = 22'd719468;
  localparam logic [DAYS_W-1:0] WDAY_BIAS = 22'd4;

  // ceiling reciprocals, exact for the operand ranges used
  localparam int DAY_K  = 41;  // seconds / 128 / 675
  localparam int HOUR_K = 29;  // second of day / 3600
  localparam int MIN_K  = 18;  // second of hour / 60
  localparam int WDAY_K = 25;  // day count / 7
  localparam int YEAR_K = 49;  // scaled day count / 146097
  localparam int C100_K = 21;  // year / 100
  localparam int C400_K = 23;  // year / 400
  localparam int MON_K  = 21;  // scaled day of year / 306
  localparam int M12_K  = 16;  // month offset / 12

  localparam logic [31:0] DAY_RECIP  = 32'(((64'd1 << DAY_K) + 64'd674) / 64'd675);
  localparam logic [17:0] HOUR_RECIP = 18'(((64'd1 << HOUR_K) + 64'd3599) / 64'd3600);
  localparam logic [12:0] MIN_RECIP  = 13'(((64'd1 << MIN_K) + 64'd59) / 64'd60);
  localparam logic [22:0] WDAY_RECIP = 23'(((64'd1 << WDAY_K) + 64'd6) / 64'd7);
  localparam logic [31:0] YEAR_RECIP = 32'(((64'd1 << YEAR_K) + 64'd146096) / 64'd146097);
  localparam logic [14:0] C100_RECIP = 15'(((64'd1 << C100_K) + 64'd99) / 64'd100);
  localparam logic [14:0] C400_RECIP = 15'(((64'd1 << C400_K) + 64'd399) / 64'd400);
  // ten times the reciprocal of 306, folds the month scale into one product
  localparam logic [16:0] MON_RECIP  = 17'(64'd10 * (((64'd1 << MON_K) + 64'd305) / 64'd306));
  // 367 times the reciprocal of 12
  localparam logic [20:0] M12_RECIP  = 21'(64'd367 * (((64'd1 << M12_K) + 64'd11) / 64'd12));

  // March-based year boundary: day of year 306 is January 1
  localparam logic [8:0] JAN_YDAY = 9'd306;

  // per-stage load enables and valid flags
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] vld;
  } ecal_ctrl_t;

endpackage

// File: sv/ecal_in_if.sv
`timescale 1ns / 1ps

interface ecal_in_if import ecal_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// File: sv/ecal_out_if.sv
`timescale 1ns / 1ps

interface ecal_out_if import ecal_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SEC_W-1:0]  second;
  logic [MIN_W-1:0]  minute;
  logic [HOUR_W-1:0] hour;
  logic [MDAY_W-1:0] day_of_month;
  logic [MON_W-1:0]  month;
  logic [YEAR_W-1:0] year;
  logic [WDAY_W-1:0] weekday;

  modport source (output valid, output second, output minute, output hour,
                  output day_of_month, output month, output year, output weekday,
                  input ready);
  modport sink   (input valid, input second, input minute, input hour,
                  input day_of_month, input month, input year, input weekday,
                  output ready);
endinterface

// File: sv/ecal_pipe_ctrl.sv
`timescale 1ns / 1ps

module ecal_pipe_ctrl import ecal_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output ecal_ctrl_t ctrl_o
);

  logic [NUM_STAGES-1:0] vld_q, vld_d;
  logic [NUM_STAGES-1:0] rdy;

  // a stage loads when it is empty or its item moves on
  assign rdy[NUM_STAGES-1] = ~vld_q[NUM_STAGES-1] | out_ready_i;
  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_rdy
    assign rdy[k] = ~vld_q[k] | rdy[k+1];
  end

  // valid flags follow the data
  always_comb begin
    vld_d = vld_q;
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = rdy[0];
  assign ctrl_o.en  = rdy;
  assign ctrl_o.vld = vld_q;

`ifndef NO_ASSERTIONS
  // input only backs up once every stage holds an item
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q))
    else $error("input stalled with an empty stage");

  // a stalled final item stays in place
  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NUM_STAGES-1] && !out_ready_i) |=> vld_q[NUM_STAGES-1])
    else $error("stalled result dropped");
`endif

endmodule

// File: sv/ecal_day_split.sv
`timescale 1ns / 1ps

module ecal_day_split import ecal_pkg::*; (
  input  logic               clk_i,
  input  ecal_ctrl_t         ctrl_i,
  input  logic [EPOCH_W-1:0] epoch_i,
  output logic [DAYS_W-1:0]  days_o,
  output logic [SOD_W-1:0]   sod_o
);

  // stage 1: clamp, detect saturation, drop the low seven bits (86400 = 128 * 675)
  logic        sat1_q;
  logic [30:0] x1_q;
  logic [6:0]  lo1_q;
  logic        neg;

  assign neg = epoch_i[EPOCH_W-1];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      sat1_q <= !neg && (epoch_i >= SAT_SECS);
      x1_q   <= neg ? '0 : epoch_i[37:7];
      lo1_q  <= neg ? '0 : epoch_i[6:0];
    end
  end

  // stage 2: quotient by 675 through the reciprocal
  logic [62:0]       day_prod;
  logic              sat2_q;
  logic [30:0]       x2_q;
  logic [6:0]        lo2_q;
  logic [DAYS_W-1:0] q2_q;

  assign day_prod = 63'(x1_q) * 63'(DAY_RECIP);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      sat2_q <= sat1_q;
      x2_q   <= x1_q;
      lo2_q  <= lo1_q;
      q2_q   <= day_prod[DAY_K+DAYS_W-1:DAY_K];
    end
  end

  // stage 3: remainder rebuilds the second of day, saturate last
  logic [30:0] rem_full;

  assign rem_full = x2_q - 31'(31'(q2_q) * 31'd675);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      days_o <= sat2_q ? LAST_DAY : q2_q;
      sod_o  <= sat2_q ? LAST_SOD : {rem_full[9:0], lo2_q};
    end
  end

endmodule

// File: sv/ecal_time_of_day.sv
`timescale 1ns / 1ps

module ecal_time_of_day import ecal_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ecal_ctrl_t        ctrl_i,
  input  logic [SOD_W-1:0]  sod_i,
  output logic [SEC_W-1:0]  second_o,
  output logic [MIN_W-1:0]  minute_o,
  output logic [HOUR_W-1:0] hour_o
);

  // stage 4: hour
  logic [34:0]       hour_prod;
  logic [SOD_W-1:0]  sod4_q;
  logic [HOUR_W-1:0] hour4_q;

  assign hour_prod = 35'(sod_i) * 35'(HOUR_RECIP);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      sod4_q  <= sod_i;
      hour4_q <= hour_prod[HOUR_K+HOUR_W-1:HOUR_K];
    end
  end

  // stage 5: second within the hour
  logic [SOD_W-1:0]  remh_full;
  logic [11:0]       remh5_q;
  logic [HOUR_W-1:0] hour5_q;

  assign remh_full = sod4_q - 17'(17'(hour4_q) * 17'd3600);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[4]) begin
      remh5_q <= remh_full[11:0];
      hour5_q <= hour4_q;
    end
  end

  // stage 6: minute
  logic [24:0]       min_prod;
  logic [11:0]       remh6_q;
  logic [HOUR_W-1:0] hour6_q;
  logic [MIN_W-1:0]  min6_q;

  assign min_prod = 25'(remh5_q) * 25'(MIN_RECIP);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[5]) begin
      remh6_q <= remh5_q;
      hour6_q <= hour5_q;
      min6_q  <= min_prod[MIN_K+MIN_W-1:MIN_K];
    end
  end

  // stage 7: second
  logic [11:0]       sec_full;
  logic [HOUR_W-1:0] hour7_q;
  logic [MIN_W-1:0]  min7_q;
  logic [SEC_W-1:0]  sec7_q;

  assign sec_full = remh6_q - 12'(12'(min6_q) * 12'd60);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[6]) begin
      hour7_q <= hour6_q;
      min7_q  <= min6_q;
      sec7_q  <= sec_full[SEC_W-1:0];
    end
  end

  // stages 8 to 10: line up with the date path
  logic [HOUR_W-1:0] hour8_q, hour9_q;
  logic [MIN_W-1:0]  min8_q, min9_q;
  logic [SEC_W-1:0]  sec8_q, sec9_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[7]) begin
      hour8_q <= hour7_q;
      min8_q  <= min7_q;
      sec8_q  <= sec7_q;
    end
    if (ctrl_i.en[8]) begin
      hour9_q <= hour8_q;
      min9_q  <= min8_q;
      sec9_q  <= sec8_q;
    end
    if (ctrl_i.en[9]) begin
      hour_o   <= hour9_q;
      minute_o <= min9_q;
      second_o <= sec9_q;
    end
  end

`ifndef NO_ASSERTIONS
  // time of day fields stay in range on a valid result
  a_tod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.vld[NUM_STAGES-1] |->
      (hour_o < 5'd24 && minute_o < 6'd60 && second_o < 6'd60))
    else $error("time of day out of range");
`endif

endmodule

// File: sv/ecal_date.sv
`timescale 1ns / 1ps

module ecal_date import ecal_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ecal_ctrl_t        ctrl_i,
  input  logic [DAYS_W-1:0] days_i,
  output logic [MDAY_W-1:0] day_of_month_o,
  output logic [MON_W-1:0]  month_o,
  output logic [YEAR_W-1:0] year_o,
  output logic [WDAY_W-1:0] weekday_o
);

  // stage 4: March-based day count, scaled for the year estimate, weekday quotient
  logic [DAYS_W-1:0] m_day;
  logic [DAYS_W-1:0] wv;
  logic [44:0]       wday_prod;
  logic [DAYS_W-1:0] m4_q;
  logic [30:0]       p4_q;
  logic [DAYS_W-1:0] wv4_q;
  logic [19:0]       q7_4_q;

  assign m_day     = days_i + MARCH_OFS;
  assign wv        = days_i + WDAY_BIAS;
  assign wday_prod = 45'(wv) * 45'(WDAY_RECIP);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      m4_q   <= m_day;
      p4_q   <= 31'(31'(m_day + 22'd2) * 31'd400);
      wv4_q  <= wv;
      q7_4_q <= wday_prod[WDAY_K+19:WDAY_K];
    end
  end

  // stage 5: year estimate, weekday
  logic [62:0]       year_prod;
  logic [DAYS_W-1:0] wrem;
  logic [DAYS_W-1:0] m5_q;
  logic [YEAR_W-1:0] year5_q;
  logic [WDAY_W-1:0] wday5_q;

  assign year_prod = 63'(p4_q) * 63'(YEAR_RECIP);
  assign wrem      = wv4_q - 22'(22'(q7_4_q) * 22'd7);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[4]) begin
      m5_q    <= m4_q;
      year5_q <= year_prod[YEAR_K+YEAR_W-1:YEAR_K];
      wday5_q <= wrem[WDAY_W-1:0];
    end
  end

  // stage 6: terms of the days before the estimated year
  logic [28:0]       c100_prod;
  logic [28:0]       c400_prod;
  logic [DAYS_W-1:0] m6_q;
  logic [YEAR_W-1:0] year6_q;
  logic [WDAY_W-1:0] wday6_q;
  logic [DAYS_W-1:0] y365_6_q;
  logic [11:0]       y4_6_q;
  logic [6:0]        q100_6_q;
  logic [4:0]        q400_6_q;

  assign c100_prod = 29'(year5_q) * 29'(C100_RECIP);
  assign c400_prod = 29'(year5_q) * 29'(C400_RECIP);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[5]) begin
      m6_q     <= m5_q;
      year6_q  <= year5_q;
      wday6_q  <= wday5_q;
      y365_6_q <= 22'(22'(year5_q) * 22'd365);
      y4_6_q   <= year5_q[YEAR_W-1:2];
      q100_6_q <= c100_prod[C100_K+6:C100_K];
      q400_6_q <= c400_prod[C400_K+4:C400_K];
    end
  end

  // stage 7: day of the estimated year, leap flag
  logic [DAYS_W-1:0] base;
  logic              leap;
  logic [22:0]       yraw7_q;
  logic              leap7_q;
  logic [YEAR_W-1:0] year7_q;
  logic [WDAY_W-1:0] wday7_q;

  assign base = y365_6_q + 22'(y4_6_q) - 22'(q100_6_q) + 22'(q400_6_q);
  assign leap = (year6_q[1:0] == 2'b00) &&
                ((14'(14'(q100_6_q) * 14'd100) != year6_q) ||
                 (14'(14'(q400_6_q) * 14'd400) == year6_q));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[6]) begin
      yraw7_q <= {1'b0, m6_q} - {1'b0, base};
      leap7_q <= leap;
      year7_q <= year6_q;
      wday7_q <= wday6_q;
    end
  end

  // stage 8: step back one year when the estimate overshoots
  logic [22:0]       yfix;
  logic [8:0]        yday8_q;
  logic [YEAR_W-1:0] year8_q;
  logic [WDAY_W-1:0] wday8_q;

  assign yfix = yraw7_q + 23'd365 + 23'(leap7_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[7]) begin
      if (yraw7_q[22]) begin
        yday8_q <= yfix[8:0];
        year8_q <= year7_q - 14'd1;
      end else begin
        yday8_q <= yraw7_q[8:0];
        year8_q <= year7_q;
      end
      wday8_q <= wday7_q;
    end
  end

  // stage 9: March-based month index
  logic [25:0]       mon_prod;
  logic [8:0]        yday9_q;
  logic [MON_W-1:0]  mon9_q;
  logic [YEAR_W-1:0] year9_q;
  logic [WDAY_W-1:0] wday9_q;

  assign mon_prod = 26'(yday8_q + 9'd31) * 26'(MON_RECIP);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[8]) begin
      yday9_q <= yday8_q;
      mon9_q  <= mon_prod[MON_K+MON_W-1:MON_K];
      year9_q <= year8_q;
      wday9_q <= wday8_q;
    end
  end

  // stage 10: day of month, move January and February into the next year
  logic [24:0] m12_prod;
  logic [8:0]  mday_full;

  assign m12_prod  = 25'(mon9_q) * 25'(M12_RECIP);
  assign mday_full = yday9_q - m12_prod[M12_K+8:M12_K] + 9'd31;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[9]) begin
      day_of_month_o <= mday_full[MDAY_W-1:0];
      weekday_o      <= wday9_q;
      if (yday9_q >= JAN_YDAY) begin
        year_o  <= year9_q + 14'd1;
        month_o <= mon9_q - 4'd10;
      end else begin
        year_o  <= year9_q;
        month_o <= mon9_q + 4'd2;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // corrected day of the March year stays within a year
  a_yday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.vld[7] |-> (yday8_q <= 9'd365))
    else $error("day of year out of range");

  // calendar fields in range on a valid result
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.vld[NUM_STAGES-1] |->
      (month_o >= 4'd1 && month_o <= 4'd12 &&
       day_of_month_o >= 5'd1 && weekday_o <= 3'd6))
    else $error("date field out of range");

  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.vld[NUM_STAGES-1] |-> (year_o >= 14'd1970 && year_o <= 14'd9999))
    else $error("year out of range");
`endif

endmodule

// File: sv/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps

// channel  dir  handshake     payload
// in_i     in   valid/ready   epoch_seconds (64, signed)
// out_o    out  valid/ready   second, minute, hour, day_of_month, month, year, weekday
//
// one transfer per cycle in each direction when the output is not stalled
// the day/second split feeds the calendar and time of day paths, which run side by side
// every stage holds a valid bit; an empty stage loads even while a later one stalls
// a stall backs up stage by stage; in_i.ready drops only once all stages are full
// reset clears the valid bits only, the datapath needs none

module epoch_seconds_to_calendar import ecal_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  ecal_in_if.sink    in_i,
  ecal_out_if.source out_o
);

  ecal_ctrl_t        ctrl;
  logic [DAYS_W-1:0] days;
  logic [SOD_W-1:0]  sod;

  // valid and enable chain
  ecal_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  // seconds to day count and second of day
  ecal_day_split u_split (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .epoch_i (in_i.epoch_seconds),
    .days_o  (days),
    .sod_o   (sod)
  );

  // hour, minute, second
  ecal_time_of_day u_tod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sod_i    (sod),
    .second_o (out_o.second),
    .minute_o (out_o.minute),
    .hour_o   (out_o.hour)
  );

  // year, month, day, weekday
  ecal_date u_date (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .days_i         (days),
    .day_of_month_o (out_o.day_of_month),
    .month_o        (out_o.month),
    .year_o         (out_o.year),
    .weekday_o      (out_o.weekday)
  );

  assign out_o.valid = ctrl.vld[NUM_STAGES-1];

endmodule
